>>> hdl/sseq_pkg.sv
// Package: constants, types and helpers for the step sequencer.
package sseq_pkg;
    localparam int MAX_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF = 8;
    localparam int CNT_W = 40;
    localparam int NOTE_W = 7;
    localparam int GATE_W = 9;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] DIR_FWD = 2'd0;
    localparam logic [1:0] DIR_REV = 2'd1;
    localparam logic [1:0] DIR_PING = 2'd2;
    localparam logic [1:0] DIR_RAND = 2'd3;

    localparam logic [1:0] CFG_BASE = 2'd0;
    localparam logic [1:0] CFG_SWING = 2'd1;
    localparam logic [1:0] CFG_LEN = 2'd2;
    localparam logic [1:0] CFG_DIR = 2'd3;

    localparam logic [31:0] BASE_RST = 32'd1536000;
    localparam logic [31:0] RNG_SEED = 32'hDEADBEEF;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] step_index;
        logic [6:0] step_note;
        logic [6:0] step_velocity;
        logic       step_slide;
        logic       step_accent;
        logic [8:0] step_gate;
    } t_in_item;

    typedef struct packed {
        logic [6:0] event_note;
        logic [6:0] event_velocity;
        logic       event_on;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [6:0] note;
        logic [6:0] vel;
        logic       slide;
        logic       accent;
        logic [8:0] gate;
    } t_entry;

    function automatic logic [6:0] pat_note(input int i);
        case (i)
            0: pat_note = 7'd48;
            1: pat_note = 7'd51;
            2: pat_note = 7'd53;
            3: pat_note = 7'd55;
            4: pat_note = 7'd58;
            5: pat_note = 7'd60;
            6: pat_note = 7'd58;
            7: pat_note = 7'd55;
            default: pat_note = 7'd0;
        endcase
    endfunction
endpackage

>>> hdl/sseq_if.sv
// Valid/ready channel interfaces for input and result beats.
interface sseq_in_if;
    logic valid;
    logic ready;
    sseq_pkg::t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface sseq_out_if;
    logic valid;
    logic ready;
    sseq_pkg::t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

>>> hdl/sseq_mul.sv
// Shift-add multiplier: 40-bit by 9-bit, one multiplier bit per cycle.
module sseq_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [39:0] i_a,
    input  logic [8:0]  i_b,
    output logic        o_done,
    output logic [48:0] o_p
);
    logic [48:0] r_acc, n_acc;
    logic [48:0] r_a, n_a;
    logic [8:0]  r_b, n_b;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;

    always_comb begin
        n_acc = r_acc;
        n_a = r_a;
        n_b = r_b;
        n_cnt = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_acc = '0;
            n_a = {9'd0, i_a};
            n_b = i_b;
            n_cnt = 4'd9;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) n_acc = r_acc + r_a;
            n_a = {r_a[47:0], 1'b0};
            n_b = {1'b0, r_b[8:1]};
            n_cnt = r_cnt - 4'd1;
            if (r_cnt == 4'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
        end
        r_acc <= n_acc;
        r_a <= n_a;
        r_b <= n_b;
    end

    assign o_done = !r_busy;
    assign o_p = r_acc;
endmodule

>>> hdl/step_sequencer_with_swing.sv
// Step sequencer top level: control sequencer, step table and event queue.
// A tick runs gate check, step length multiply, compare, a bit-serial modulo in
// random mode, new step length multiply, gate multiply (skipped on a rest) and emit;
// without a step boundary compare goes to emit. Writes and restarts finish in idle.
// One beat in work at a time; input waits until the two-entry output queue drains.
// Synchronous active-low reset loads the default pattern, registers and seed.
module step_sequencer_with_swing #(
    parameter int MAX_STEPS = sseq_pkg::MAX_STEPS_DEF,
    parameter int FRAC_BITS = sseq_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sseq_in_if.sink     in_ch,
    sseq_out_if.source  out_ch,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int PW = $clog2(MAX_STEPS);
    localparam int LW = $clog2(MAX_STEPS + 1);
    localparam logic [39:0] ONE = 40'd1 << FRAC_BITS;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_GATE = 8'b0000_0010,
        S_LEN0 = 8'b0000_0100,
        S_CMP  = 8'b0000_1000,
        S_MOD  = 8'b0001_0000,
        S_LEN1 = 8'b0010_0000,
        S_GMUL = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } t_state;

    t_state r_st, n_st;
    logic [31:0] r_base;
    logic [8:0]  r_swing;
    logic [4:0]  r_len;
    logic [1:0]  r_dir;

    sseq_pkg::t_entry r_tab [MAX_STEPS];
    logic [PW-1:0] r_pos;
    logic r_up, r_snd, r_run;
    logic [6:0] r_held;
    logic [39:0] r_tc, r_gl, r_stp;
    logic [31:0] r_rng;
    logic [LW-1:0] r_ln;

    // modulo unit state
    logic [31:0] r_mq;
    logic [LW-1:0] r_mr;
    logic [5:0] r_mc;

    // output queue, two entries
    sseq_pkg::t_out_item r_q [2];
    logic [1:0] r_qn;
    // pending events of the current tick
    sseq_pkg::t_out_item r_ev [2];
    logic [1:0] r_evn;

    // multiplier
    logic m_start, m_done;
    logic [39:0] m_a;
    logic [8:0] m_b;
    logic [48:0] m_p;
    sseq_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(m_start), .i_a(m_a),
        .i_b(m_b), .o_done(m_done), .o_p(m_p));

    logic r_mwait;

    logic [8:0] sw_sat;
    assign sw_sat = (r_swing > 9'd256) ? 9'd256 : r_swing;
    function automatic logic [8:0] swf(input logic odd, input logic [8:0] s);
        swf = odd ? s : 9'd256 - s;
    endfunction

    logic [39:0] len_res;
    logic [41:0] sh7;
    assign sh7 = m_p[48:7];
    assign len_res = (sh7 < {2'd0, ONE}) ? ONE : sh7[39:0];

    sseq_pkg::t_entry cur_e;
    assign cur_e = r_tab[r_pos];

    logic [8:0] g_cl;
    always_comb begin
        g_cl = cur_e.gate;
        if (g_cl < 9'd26) g_cl = 9'd26;
        if (g_cl > 9'd256) g_cl = 9'd256;
    end
    logic [7:0] v_acc;
    assign v_acc = cur_e.accent ? ((({1'b0, cur_e.vel} + 8'd40) > 8'd127) ? 8'd127 :
        ({1'b0, cur_e.vel} + 8'd40)) : {1'b0, cur_e.vel};

    logic [31:0] rx1, rx2, rx3;
    assign rx1 = r_rng ^ (r_rng << 13);
    assign rx2 = rx1 ^ (rx1 >> 17);
    assign rx3 = rx2 ^ (rx2 << 5);

    // modulo step: restoring remainder, one dividend bit per cycle
    logic [LW:0] m_trial;
    assign m_trial = {r_mr, r_mq[31]};

    assign in_ch.ready = (r_st == S_IDLE) && (r_qn == 2'd0);
    assign out_ch.valid = (r_qn != 2'd0);
    assign out_ch.data = r_q[0];

    logic acc_in, pop;
    assign acc_in = in_ch.valid && in_ch.ready;
    assign pop = out_ch.valid && out_ch.ready;

    always_comb begin
        m_start = 1'b0;
        m_a = {8'd0, r_base};
        m_b = swf(r_pos[0], sw_sat);
        if (r_st == S_GATE && !r_mwait) m_start = 1'b1;
        if (r_st == S_LEN1 && !r_mwait) m_start = 1'b1;
        if (r_st == S_GMUL && !r_mwait) begin
            m_start = cur_e.vel != 7'd0;
            m_a = r_stp;
            m_b = g_cl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_base <= sseq_pkg::BASE_RST;
            r_swing <= 9'd128;
            r_len <= 5'd8;
            r_dir <= sseq_pkg::DIR_FWD;
            for (int i = 0; i < MAX_STEPS; i++) begin
                r_tab[i].note <= (i < 8) ? sseq_pkg::pat_note(i) : 7'd0;
                r_tab[i].vel <= (i < 8) ? 7'd100 : 7'd0;
                r_tab[i].slide <= 1'b0;
                r_tab[i].accent <= 1'b0;
                r_tab[i].gate <= (i < 8) ? 9'd128 : 9'd0;
            end
            r_pos <= '0;
            r_up <= 1'b1;
            r_snd <= 1'b0;
            r_run <= 1'b0;
            r_held <= '0;
            r_tc <= '0;
            r_gl <= '0;
            r_rng <= sseq_pkg::RNG_SEED;
            r_qn <= '0;
            r_evn <= '0;
            r_mwait <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sseq_pkg::CFG_BASE:  r_base <= i_cfg_data;
                    sseq_pkg::CFG_SWING: r_swing <= i_cfg_data[8:0];
                    sseq_pkg::CFG_LEN:   r_len <= i_cfg_data[4:0];
                    sseq_pkg::CFG_DIR:   r_dir <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (pop) begin
                r_q[0] <= r_q[1];
                r_qn <= r_qn - 2'd1;
            end
            case (r_st)
                S_IDLE: begin
                    if (acc_in) begin
                        r_evn <= '0;
                        case (in_ch.data.op)
                            sseq_pkg::OP_WRITE: begin
                                if (32'(in_ch.data.step_index) < MAX_STEPS)
                                    r_tab[in_ch.data.step_index[PW-1:0]] <= '{
                                        note: in_ch.data.step_note,
                                        vel: in_ch.data.step_velocity,
                                        slide: in_ch.data.step_slide,
                                        accent: in_ch.data.step_accent,
                                        gate: in_ch.data.step_gate};
                            end
                            sseq_pkg::OP_RESTART: begin
                                r_pos <= '0;
                                r_up <= 1'b1;
                                r_snd <= 1'b0;
                                r_held <= '0;
                                r_tc <= '0;
                                r_gl <= '0;
                                r_run <= 1'b0;
                            end
                            sseq_pkg::OP_TICK: begin
                                if (r_len != 5'd0) begin
                                    r_ln <= (32'(r_len) > MAX_STEPS) ? LW'(MAX_STEPS)
                                        : LW'(r_len);
                                    r_tc <= (r_run ? r_tc : {8'd0, r_base}) + ONE;
                                    r_run <= 1'b1;
                                    r_st <= S_GATE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_GATE: begin
                    // gate-off check; step length multiply starts here
                    if (r_snd && r_tc >= r_gl && !cur_e.slide) begin
                        r_ev[0] <= '{event_note: r_held, event_velocity: 7'd0,
                            event_on: 1'b0, last: 1'b0};
                        r_evn <= 2'd1;
                        r_snd <= 1'b0;
                    end
                    r_mwait <= 1'b1;
                    r_st <= S_LEN0;
                end
                S_LEN0: begin
                    if (m_done) begin
                        r_mwait <= 1'b0;
                        r_stp <= len_res;
                        r_st <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_tc >= r_stp) begin
                        r_tc <= r_tc - r_stp;
                        case (r_dir)
                            sseq_pkg::DIR_FWD: begin
                                if ({1'b0, r_pos} + 1'b1 >= (PW+1)'(r_ln)) r_pos <= '0;
                                else r_pos <= r_pos + 1'b1;
                                r_st <= S_LEN1;
                            end
                            sseq_pkg::DIR_REV: begin
                                if (r_pos == '0) r_pos <= PW'(r_ln - 1'b1);
                                else r_pos <= r_pos - 1'b1;
                                r_st <= S_LEN1;
                            end
                            sseq_pkg::DIR_PING: begin
                                logic [PW+1:0] p;
                                logic [PW+1:0] lm;
                                logic u;
                                p = r_up ? {2'b00, r_pos} + 1'b1 : {2'b00, r_pos} - 1'b1;
                                lm = (PW+2)'(r_ln) - 1'b1;
                                u = r_up;
                                if ($signed(p) >= $signed(lm)) begin
                                    p = lm;
                                    u = 1'b0;
                                end
                                // bottom rule wins when length is one
                                if ($signed(p) <= 0) begin
                                    p = '0;
                                    u = 1'b1;
                                end
                                r_up <= u;
                                r_pos <= p[PW-1:0];
                                r_st <= S_LEN1;
                            end
                            default: begin
                                r_rng <= rx3;
                                r_mq <= rx3;
                                r_mr <= '0;
                                r_mc <= 6'd32;
                                r_st <= S_MOD;
                            end
                        endcase
                    end else begin
                        r_st <= S_EMIT;
                    end
                end
                S_MOD: begin
                    // 32 remainder steps, then the position is loaded from the remainder
                    if (r_mc == 6'd0) begin
                        r_pos <= r_mr[PW-1:0];
                        r_st <= S_LEN1;
                    end else begin
                        if (m_trial >= {1'b0, r_ln}) r_mr <= LW'(m_trial - {1'b0, r_ln});
                        else r_mr <= m_trial[LW-1:0];
                        r_mq <= {r_mq[30:0], 1'b0};
                        r_mc <= r_mc - 6'd1;
                    end
                end
                S_LEN1: begin
                    // new step's length
                    if (!r_mwait) r_mwait <= 1'b1;
                    else if (m_done) begin
                        r_mwait <= 1'b0;
                        r_stp <= len_res;
                        r_st <= S_GMUL;
                    end
                end
                S_GMUL: begin
                    if (cur_e.vel == 7'd0) begin
                        r_gl <= {1'b0, r_stp[39:1]};
                        if (r_snd) begin
                            r_ev[r_evn[0]] <= '{event_note: r_held, event_velocity: 7'd0,
                                event_on: 1'b0, last: 1'b0};
                            r_evn <= r_evn + 2'd1;
                            r_snd <= 1'b0;
                        end
                        r_st <= S_EMIT;
                    end else if (!r_mwait) begin
                        r_mwait <= 1'b1;
                    end else if (m_done) begin
                        r_mwait <= 1'b0;
                        r_gl <= m_p[47:8];
                        if (r_evn[0]) begin
                            // gate-off already queued; note-on follows it
                            r_ev[1] <= '{event_note: cur_e.note, event_velocity: v_acc[6:0],
                                event_on: 1'b1, last: 1'b0};
                            r_evn <= 2'd2;
                        end else begin
                            r_ev[0] <= '{event_note: cur_e.note, event_velocity: v_acc[6:0],
                                event_on: 1'b1, last: 1'b0};
                            r_ev[1] <= '{event_note: r_held, event_velocity: 7'd0,
                                event_on: 1'b0, last: 1'b0};
                            r_evn <= r_snd ? 2'd2 : 2'd1;
                        end
                        r_held <= cur_e.note;
                        r_snd <= 1'b1;
                        r_st <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // queue is empty here: a tick only starts with it drained
                    r_q[0] <= {r_ev[0].event_note, r_ev[0].event_velocity,
                        r_ev[0].event_on, r_evn == 2'd1};
                    r_q[1] <= {r_ev[1].event_note, r_ev[1].event_velocity,
                        r_ev[1].event_on, r_evn == 2'd2};
                    r_qn <= r_evn;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
